### design/lpd_pkg.sv
// Package for the link packet deframer: codes for the result kind, status
// and configuration index, packet framing constants and the byte-wide CRC step.
// No dependencies.
`default_nettype none

package lpd_pkg;

  localparam int unsigned HDR_BYTES     = 3;
  localparam int unsigned TRAILER_BYTES = 4;
  localparam int unsigned POS_W         = 9;

  localparam logic [7:0]  SYNC_RESET = 8'hAA;
  localparam logic [31:0] POLY_RESET = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;

  localparam logic [POS_W-1:0] POS_SYNC   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_LENGTH = POS_W'(1);
  localparam logic [POS_W-1:0] POS_OFFSET = POS_W'(2);
  localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};

  // Payload indexes with a fixed meaning.
  localparam logic [POS_W-1:0] IDX_MSG_TYPE   = POS_W'(1);
  localparam logic [POS_W-1:0] IDX_FIRST_DATA = POS_W'(2);

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_TOO_SHORT     = 3'd1,
    ST_BAD_HEADER    = 3'd2,
    ST_SIZE_MISMATCH = 3'd3,
    ST_PAYLOAD_SHORT = 3'd4,
    ST_CRC           = 3'd5
  } status_t;

  typedef enum logic {
    CFG_SYNC_BYTE = 1'b0,
    CFG_CRC_POLY  = 1'b1
  } cfg_index_t;

  // One byte of a reflected CRC, LSB first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc,
                                           input logic [7:0]  b,
                                           input logic [31:0] poly);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ poly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### design/link_packet_deframer.sv
// Link packet deframer top level: input stage, byte decoder and result register.
// Depends on lpd_pkg.
`default_nettype none

// Usage
// - Input channel (in_valid/in_ready): one received byte per transfer, with
//   in_end_of_packet high on the last byte of the packet.
// - Result channel (out_valid/out_ready): a data result (out_kind = data) for
//   each decoded message byte, and one status result on the end-marked byte.
//   On any nonzero status the consumer drops the data bytes of that packet.
// - Configuration channel (cfg_valid/cfg_ready): sync byte at index 0, CRC
//   polynomial at index 1. Always ready; write only while the block is idle.
// - A result is registered twice after its byte's transfer: first in the input
//   register, then in the result register.
// - Throughput: one byte per cycle unless the result side stalls. The CRC update
//   is one unrolled byte step between the input register and the result register.
// - A stall on the result side holds the result register; the input register
//   still takes one more byte, then in_ready follows out_ready.
// - Reset clears the packet state, both pipeline valids and restores the
//   configuration registers to sync 0xAA and polynomial 0xEDB88320.
module link_packet_deframer (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  [7:0]               in_rx_byte,
  input  wire                      in_end_of_packet,
  output logic                     out_valid,
  input  wire                      out_ready,
  output lpd_pkg::kind_t           out_kind,
  output logic [7:0]               out_data_byte,
  output logic [7:0]               out_data_index,
  output lpd_pkg::status_t         out_status,
  output logic [7:0]               out_msg_type,
  output logic [7:0]               out_data_len,
  output logic [7:0]               out_cmd_id,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire  lpd_pkg::cfg_index_t cfg_index,
  input  wire  [31:0]              cfg_wdata
);
  import lpd_pkg::*;

  // Configuration.
  logic [7:0]  sync_byte_r;
  logic [31:0] crc_poly_r;

  // Input stage.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_eop_r;
  logic       s1_adv;

  // Packet state.
  logic [POS_W-1:0] byte_pos_r, byte_pos_nxt;
  logic [7:0]       decl_len_r, decl_len_nxt;
  logic             chain_live_r, chain_live_nxt;
  logic [POS_W-1:0] next_mark_r, next_mark_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [31:0]      rx_crc_r, rx_crc_nxt;
  logic             hdr_good_r, hdr_good_nxt;
  logic [7:0]       msg_type_r, msg_type_nxt;
  logic [7:0]       first_data_r, first_data_nxt;

  // Decode results.
  logic [POS_W-1:0] idx;
  logic [POS_W-1:0] data_idx_full;
  logic [7:0]       dec_byte;
  logic             have_data;
  logic [1:0]       crc_shift;
  logic [POS_W:0]   pkt_size;
  logic [7:0]       dl_calc;
  status_t          st;
  logic             has_result;

  // Result register.
  logic    out_valid_r;
  kind_t   out_kind_r;
  logic [7:0] out_data_byte_r, out_data_index_r;
  status_t out_status_r;
  logic [7:0] out_msg_type_r, out_data_len_r, out_cmd_id_r;

  assign cfg_ready = 1'b1;
  assign s1_adv    = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_byte_r <= SYNC_RESET;
      crc_poly_r  <= POLY_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SYNC_BYTE: sync_byte_r <= cfg_wdata[7:0];
        CFG_CRC_POLY:  crc_poly_r  <= cfg_wdata;
        default:       crc_poly_r  <= crc_poly_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_rx_byte;
      s1_eop_r  <= in_end_of_packet;
    end
  end

  always_comb begin
    byte_pos_nxt   = byte_pos_r;
    decl_len_nxt   = decl_len_r;
    chain_live_nxt = chain_live_r;
    next_mark_nxt  = next_mark_r;
    crc_nxt        = crc_r;
    rx_crc_nxt     = rx_crc_r;
    hdr_good_nxt   = hdr_good_r;
    msg_type_nxt   = msg_type_r;
    first_data_nxt = first_data_r;
    idx            = byte_pos_r - POS_W'(HDR_BYTES);
    data_idx_full  = idx - IDX_FIRST_DATA;
    dec_byte       = s1_byte_r;
    have_data      = 1'b0;
    crc_shift      = idx[1:0] - decl_len_r[1:0];

    case (byte_pos_r)
      POS_SYNC:   hdr_good_nxt = (s1_byte_r == sync_byte_r);
      POS_LENGTH: decl_len_nxt = s1_byte_r;
      POS_OFFSET: begin
        chain_live_nxt = (s1_byte_r != 8'd0);
        next_mark_nxt  = {1'b0, s1_byte_r};
      end
      default: begin
        if (idx < {1'b0, decl_len_r}) begin
          // A marked byte carries the distance to the next mark and stands for
          // the sync value.
          if (chain_live_r && idx == next_mark_r) begin
            dec_byte = sync_byte_r;
            if (s1_byte_r == 8'd0) begin
              chain_live_nxt = 1'b0;
            end else begin
              next_mark_nxt = idx + {1'b0, s1_byte_r};
            end
          end
          if (({1'b0, idx} + (POS_W+1)'(TRAILER_BYTES)) < {2'b00, decl_len_r}) begin
            crc_nxt = crc_byte(crc_r, dec_byte, crc_poly_r);
            if (idx == IDX_MSG_TYPE) begin
              msg_type_nxt = dec_byte;
            end
            if (idx >= IDX_FIRST_DATA) begin
              if (idx == IDX_FIRST_DATA) begin
                first_data_nxt = dec_byte;
              end
              have_data = 1'b1;
            end
          end else begin
            // Trailer bytes build the received CRC little-endian.
            rx_crc_nxt = rx_crc_r | ({24'd0, dec_byte} << {crc_shift, 3'b000});
          end
        end
      end
    endcase

    if (byte_pos_r != POS_MAX) begin
      byte_pos_nxt = byte_pos_r + POS_W'(1);
    end

    pkt_size = {1'b0, byte_pos_r} + (POS_W+1)'(1);
    dl_calc  = decl_len_r - 8'(TRAILER_BYTES + 2);
    if (pkt_size < (POS_W+1)'(HDR_BYTES + TRAILER_BYTES)) begin
      st = ST_TOO_SHORT;
    end else if (!hdr_good_nxt) begin
      st = ST_BAD_HEADER;
    end else if (pkt_size != ((POS_W+1)'(HDR_BYTES) + {2'b00, decl_len_nxt})) begin
      st = ST_SIZE_MISMATCH;
    end else if (decl_len_nxt < 8'(TRAILER_BYTES + 2)) begin
      st = ST_PAYLOAD_SHORT;
    end else if (~crc_nxt != rx_crc_nxt) begin
      st = ST_CRC;
    end else begin
      st = ST_OK;
    end
    // In the size checks above, decl_len_nxt equals decl_len_r beyond the header.
    if (decl_len_nxt != decl_len_r) begin
      dl_calc = decl_len_nxt - 8'(TRAILER_BYTES + 2);
    end

    has_result = s1_eop_r || have_data;

    // The end-marked byte closes the packet.
    if (s1_eop_r) begin
      byte_pos_nxt   = '0;
      decl_len_nxt   = '0;
      chain_live_nxt = 1'b0;
      next_mark_nxt  = '0;
      crc_nxt        = CRC_INIT;
      rx_crc_nxt     = '0;
      hdr_good_nxt   = 1'b0;
      msg_type_nxt   = '0;
      first_data_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r   <= '0;
      decl_len_r   <= '0;
      chain_live_r <= 1'b0;
      next_mark_r  <= '0;
      crc_r        <= CRC_INIT;
      rx_crc_r     <= '0;
      hdr_good_r   <= 1'b0;
      msg_type_r   <= '0;
      first_data_r <= '0;
    end else if (s1_valid_r && s1_adv) begin
      byte_pos_r   <= byte_pos_nxt;
      decl_len_r   <= decl_len_nxt;
      chain_live_r <= chain_live_nxt;
      next_mark_r  <= next_mark_nxt;
      crc_r        <= crc_nxt;
      rx_crc_r     <= rx_crc_nxt;
      hdr_good_r   <= hdr_good_nxt;
      msg_type_r   <= msg_type_nxt;
      first_data_r <= first_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r && has_result;
    end
  end

  // A good packet ends inside its trailer, so the holds are already final when
  // the end-marked byte arrives.
  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r && has_result) begin
      if (s1_eop_r) begin
        out_kind_r       <= KIND_STATUS;
        out_data_byte_r  <= '0;
        out_data_index_r <= '0;
        out_status_r     <= st;
        if (st == ST_OK) begin
          out_msg_type_r <= msg_type_r;
          out_data_len_r <= dl_calc;
          out_cmd_id_r   <= (dl_calc != 8'd0) ? first_data_r : 8'd0;
        end else begin
          out_msg_type_r <= '0;
          out_data_len_r <= '0;
          out_cmd_id_r   <= '0;
        end
      end else begin
        out_kind_r       <= KIND_DATA;
        out_data_byte_r  <= dec_byte;
        out_data_index_r <= data_idx_full[7:0];
        out_status_r     <= ST_OK;
        out_msg_type_r   <= '0;
        out_data_len_r   <= '0;
        out_cmd_id_r     <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_data_byte  = out_data_byte_r;
  assign out_data_index = out_data_index_r;
  assign out_status     = out_status_r;
  assign out_msg_type   = out_msg_type_r;
  assign out_data_len   = out_data_len_r;
  assign out_cmd_id     = out_cmd_id_r;

endmodule

`default_nettype wire
